/* rtl/rfr_pkg.sv */
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types, widths and constants of the rotating ring generator.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int unsigned DEPTH_DEF     = 8;
  localparam int unsigned WORD_BITS_DEF = 29;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned SEED_W  = 8;
  localparam int unsigned SIDES_W = 30;
  localparam int unsigned VALUE_W = 29;
  localparam int unsigned CELL_W  = 32;

  localparam logic [CELL_W-1:0] BYTE_MASK = 32'h0000_00FF;
  localparam logic [CELL_W-1:0] HALF_MASK = 32'h0000_FFFF;

  localparam int unsigned MAX_RETRIES = 4096;
  localparam int unsigned TRY_W       = $clog2(MAX_RETRIES + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_ABSORB = 3'd1,
    CMD_BYTE   = 3'd2,
    CMD_HALF   = 3'd3,
    CMD_WORD   = 3'd4,
    CMD_DICE   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    RING_HOLD,
    RING_CLEAR,
    RING_ADD,
    RING_SPIN
  } ring_op_e;

  typedef enum logic [2:0] {
    RES_BYTE,
    RES_HALF,
    RES_WORD,
    RES_ZERO,
    RES_REM
  } res_sel_e;

  typedef struct packed {
    ring_op_e ring_op;
    logic     load_sides;
    logic     div_start;
    logic     div_cell;
    logic     res_load;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic sides_zero;
    logic sides_over;
    logic div_done;
    logic below_limit;
    logic slot_free;
  } dp_sts_t;

endpackage

/* rtl/rfr_cmd_if.sv */
// ----------------------------------------------------------------------------
// rfr_cmd_if
// Command channel: one beat carries a command and its operands.
// ----------------------------------------------------------------------------
interface rfr_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [rfr_pkg::CMD_W-1:0]   command;
  logic [rfr_pkg::SEED_W-1:0]  seed_byte;
  logic [rfr_pkg::SIDES_W-1:0] sides;

  modport source (output valid, command, seed_byte, sides, input ready);
  modport sink   (input valid, command, seed_byte, sides, output ready);
endinterface

/* rtl/rfr_res_if.sv */
// ----------------------------------------------------------------------------
// rfr_res_if
// Result channel: one beat carries a drawn value or dice result.
// ----------------------------------------------------------------------------
interface rfr_res_if;
  logic                        valid;
  logic                        ready;
  logic [rfr_pkg::VALUE_W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

/* rtl/rfr_div.sv */
// ----------------------------------------------------------------------------
// rfr_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rfr_div #(
  parameter int unsigned DIV_W = rfr_pkg::WORD_BITS_DEF + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rfr_pkg::CELL_W-1:0]  dividend_i,
  input  logic [rfr_pkg::SIDES_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [rfr_pkg::SIDES_W-1:0] rem_o
);
  import rfr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_W-1:0]   dvd_q;
  logic [SIDES_W-1:0] rem_q;
  logic [SIDES_W:0]   trial;
  logic [SIDES_W:0]   diff;

  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i[DIV_W-1:0];
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_q <= diff[SIDES_W-1:0];
      end else begin
        rem_q <= trial[SIDES_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/rfr_dp.sv */
// ----------------------------------------------------------------------------
// rfr_dp
// Datapath: cell ring with spin and absorb, operand and result registers.
// ----------------------------------------------------------------------------
module rfr_dp #(
  parameter int unsigned DEPTH     = rfr_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = rfr_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rfr_pkg::dp_cmd_t            cmd_i,
  output rfr_pkg::dp_sts_t            sts_o,
  input  logic [rfr_pkg::SEED_W-1:0]  seed_byte_i,
  input  logic [rfr_pkg::SIDES_W-1:0] sides_i,
  input  logic                        res_ready_i,
  output logic                        res_valid_o,
  output logic [rfr_pkg::VALUE_W-1:0] res_value_o
);
  import rfr_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CELL_W-1:0] SPAN      = 32'd1 << WORD_BITS;
  localparam logic [CELL_W-1:0] CELL_MASK = SPAN - 32'd1;
  localparam logic [CELL_W-1:0] TOP_BIT   = 32'd1 << (WORD_BITS - 1);

  logic [CELL_W-1:0]  cells_q [DEPTH];
  logic [CELL_W-1:0]  cells_d [DEPTH];
  logic [CELL_W-1:0]  spun    [DEPTH];
  logic [CELL_W-1:0]  added   [DEPTH];
  logic [IDX_W-1:0]   aidx_q, aidx_d;
  logic [CELL_W-1:0]  seed_ext;
  logic [SIDES_W-1:0] sides_q;
  logic               res_valid_q;
  logic [VALUE_W-1:0] res_q;
  logic [VALUE_W-1:0] res_d;
  logic [CELL_W-1:0]  cell0;
  logic [CELL_W-1:0]  limit;
  logic               div_done;
  logic [SIDES_W-1:0] rem;

  assign cell0    = cells_q[0];
  assign seed_ext = {{(CELL_W - SEED_W){seed_byte_i[SEED_W-1]}}, seed_byte_i};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned N1 = (i + 1) % DEPTH;
    localparam int unsigned N2 = (i + 2) % DEPTH;
    logic [CELL_W-1:0] rot;
    assign rot      = (cells_q[N2] >> 1) | (cells_q[N2][0] ? TOP_BIT : '0);
    assign spun[i]  = (cells_q[N1] + rot) & CELL_MASK;
    assign added[i] = cells_q[i] + ((aidx_q == IDX_W'(i)) ? seed_ext : '0);
  end

  always_comb begin
    cells_d = cells_q;
    aidx_d  = aidx_q;
    case (cmd_i.ring_op)
      RING_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) cells_d[i] = '0;
        aidx_d = '0;
      end
      RING_ADD: begin
        cells_d = added;
        aidx_d  = (aidx_q == IDX_W'(DEPTH - 1)) ? '0 : aidx_q + 1'b1;
      end
      RING_SPIN: cells_d = spun;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) cells_q[i] <= '0;
      aidx_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      cells_q <= cells_d;
      aidx_q  <= aidx_d;
      if (cmd_i.res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  rfr_div #(
    .DIV_W (WORD_BITS + 1)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_cell ? cell0 : SPAN),
    .divisor_i  (sides_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign limit = SPAN - CELL_W'(rem);

  always_comb begin
    case (cmd_i.res_sel)
      RES_BYTE: res_d = VALUE_W'(cell0 & BYTE_MASK);
      RES_HALF: res_d = VALUE_W'(cell0 & HALF_MASK);
      RES_WORD: res_d = cell0[VALUE_W-1:0];
      RES_REM:  res_d = rem[VALUE_W-1:0];
      default:  res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sides) sides_q <= sides_i;
    if (cmd_i.res_load)   res_q   <= res_d;
  end

  assign sts_o.sides_zero  = (sides_q == '0);
  assign sts_o.sides_over  = (CELL_W'(sides_q) > SPAN);
  assign sts_o.div_done    = div_done;
  assign sts_o.below_limit = (cell0 < limit);
  assign sts_o.slot_free   = !res_valid_q || res_ready_i;

  assign res_valid_o = res_valid_q;
  assign res_value_o = res_q;

endmodule

/* rtl/rfr_ctrl.sv */
// ----------------------------------------------------------------------------
// rfr_ctrl
// Command sequencer: decodes beats and steps ring, divider and output.
// ----------------------------------------------------------------------------
module rfr_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  logic [rfr_pkg::CMD_W-1:0] cmd_code_i,
  output logic                      cmd_ready_o,
  output rfr_pkg::dp_cmd_t          dp_cmd_o,
  input  rfr_pkg::dp_sts_t          dp_sts_i
);
  import rfr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPIN,
    ST_DICE,
    ST_DSPAN,
    ST_CHECK,
    ST_DCELL,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  res_sel_e         sel_q, sel_d;
  logic [TRY_W-1:0] tries_q, tries_d;

  always_comb begin
    state_d  = state_q;
    sel_d    = sel_q;
    tries_d  = tries_q;
    dp_cmd_o = '{ring_op: RING_HOLD, load_sides: 1'b0, div_start: 1'b0,
                 div_cell: 1'b0, res_load: 1'b0, res_sel: sel_q};
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_e'(cmd_code_i))
            CMD_CLEAR:  dp_cmd_o.ring_op = RING_CLEAR;
            CMD_ABSORB: begin
              dp_cmd_o.ring_op = RING_ADD;
              state_d          = ST_SPIN;
            end
            CMD_BYTE, CMD_HALF, CMD_WORD: begin
              dp_cmd_o.ring_op = RING_SPIN;
              state_d          = ST_EMIT;
              case (cmd_e'(cmd_code_i))
                CMD_BYTE: sel_d = RES_BYTE;
                CMD_HALF: sel_d = RES_HALF;
                default:  sel_d = RES_WORD;
              endcase
            end
            CMD_DICE: begin
              dp_cmd_o.load_sides = 1'b1;
              state_d             = ST_DICE;
            end
            default: ;
          endcase
        end
      end
      ST_SPIN: begin
        dp_cmd_o.ring_op = RING_SPIN;
        state_d          = ST_IDLE;
      end
      ST_DICE: begin
        tries_d = '0;
        if (dp_sts_i.sides_zero) begin
          dp_cmd_o.ring_op = RING_SPIN;
          sel_d            = RES_ZERO;
          state_d          = ST_EMIT;
        end else if (dp_sts_i.sides_over) begin
          dp_cmd_o.ring_op = RING_SPIN;
          sel_d            = RES_WORD;
          state_d          = ST_EMIT;
        end else begin
          dp_cmd_o.div_start = 1'b1;
          state_d            = ST_DSPAN;
        end
      end
      ST_DSPAN: begin
        if (dp_sts_i.div_done) begin
          dp_cmd_o.ring_op = RING_SPIN;
          state_d          = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (dp_sts_i.below_limit || (tries_q >= TRY_W'(MAX_RETRIES))) begin
          dp_cmd_o.div_start = 1'b1;
          dp_cmd_o.div_cell  = 1'b1;
          state_d            = ST_DCELL;
        end else begin
          dp_cmd_o.ring_op = RING_SPIN;
          tries_d          = tries_q + 1'b1;
        end
      end
      ST_DCELL: begin
        if (dp_sts_i.div_done) begin
          sel_d   = RES_REM;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (dp_sts_i.slot_free) begin
          dp_cmd_o.res_load = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= RES_ZERO;
      tries_q <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      tries_q <= tries_d;
    end
  end

  assign cmd_ready_o = (state_q == ST_IDLE);

endmodule

/* rtl/rotating_fibonacci_ring_rng.sv */
// ----------------------------------------------------------------------------
// rotating_fibonacci_ring_rng
// Lagged-Fibonacci style generator over a ring of DEPTH cells.
// ----------------------------------------------------------------------------
// One command beat is taken at a time; a finished result sits in an output
// register, so the next command is taken while it waits. Clear empties the
// ring, absorb adds the seed byte and then spins, and each draw spins and
// then loads the output register. Dice with zero sides or sides above
// 2^WORD_BITS spins the ring once; otherwise the one-bit-per-cycle remainder
// unit runs once for the acceptance limit and once for the final remainder,
// with a ring spin for each candidate drawn. The ring is held in flip-flops
// and is zero right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module rotating_fibonacci_ring_rng #(
  parameter int unsigned DEPTH     = rfr_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = rfr_pkg::WORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rfr_cmd_if.sink   cmd_i,
  rfr_res_if.source res_o
);
  import rfr_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  rfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_code_i  (cmd_i.command),
    .cmd_ready_o (cmd_i.ready),
    .dp_cmd_o    (dp_cmd),
    .dp_sts_i    (dp_sts)
  );

  rfr_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .seed_byte_i (cmd_i.seed_byte),
    .sides_i     (cmd_i.sides),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .res_value_o (res_o.value)
  );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotating ring generator. A shadow ring tracks
// every accepted command beat and queues the value each draw or dice roll
// must return; the result monitor compares each returned beat in order.
// Stimulus runs from directed corners through host-style seeding sequences,
// a long receiver hold-off, a gap-free stretch and random command noise.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rfr_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned WORD_BITS    = WORD_BITS_DEF;
  localparam logic [31:0] CELL_MASK    = 32'((64'h1 << WORD_BITS) - 64'h1);
  localparam logic [31:0] TOP_BIT      = 32'h1 << (WORD_BITS - 1);
  localparam logic [63:0] SPAN         = 64'h1 << WORD_BITS;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int unsigned IDLE_LIMIT   = 40000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  rfr_cmd_if cmd_bus ();
  rfr_res_if res_bus ();

  rotating_fibonacci_ring_rng i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  logic [31:0]        ring_shadow [DEPTH];
  logic [7:0]         absorb_slot;
  logic [VALUE_W-1:0] pending_values [$];
  int unsigned        error_count;
  int unsigned        beats_sent;
  int unsigned        idle_cycles;
  int unsigned        rx_hold_req;
  bit                 tx_steady;
  bit                 rx_steady;

  function automatic void flag_error(string msg);
    if (error_count < 10) $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SIDES_W-1:0] pick_sides();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SIDES_W'($urandom_range(1, 100));
      4:          return SIDES_W'(1) << $urandom_range(0, 29);
      5:          return 30'h1000_0000 + SIDES_W'($urandom_range(1, 1000));
      6:          return SIDES_W'($urandom);
      7:          return '0;
      8:          return SIDES_W'($urandom_range(30'h2000_0001, 30'h3FFF_FFFF));
      default:    return SIDES_W'($urandom_range(1, 30'h2000_0000));
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_draw();
    case ($urandom_range(0, 3))
      0:       return CMD_BYTE;
      1:       return CMD_HALF;
      2:       return CMD_WORD;
      default: return CMD_DICE;
    endcase
  endfunction

  function automatic void advance_ring();
    logic [31:0] prev [DEPTH];
    logic [31:0] b;
    logic [31:0] rot;
    prev = ring_shadow;
    for (int i = 0; i < DEPTH; i++) begin
      b   = prev[(i + 2) % DEPTH];
      rot = (b >> 1) | (b[0] ? TOP_BIT : 32'h0);
      ring_shadow[i] = (prev[(i + 1) % DEPTH] + rot) & CELL_MASK;
    end
  endfunction

  function automatic logic [31:0] roll_shadow(logic [SIDES_W-1:0] n);
    logic [31:0] lim;
    int unsigned tries;
    if (n == '0) begin
      advance_ring();
      return 32'h0;
    end
    if (64'(n) > SPAN) begin
      advance_ring();
      return ring_shadow[0];
    end
    lim   = 32'((SPAN / 64'(n)) * 64'(n));
    tries = 0;
    forever begin
      advance_ring();
      if (ring_shadow[0] < lim || tries >= MAX_RETRIES) break;
      tries++;
    end
    return ring_shadow[0] % 32'(n);
  endfunction

  function automatic bit predict_command(logic [CMD_W-1:0] op, logic [SEED_W-1:0] seed,
                                         logic [SIDES_W-1:0] n, output logic [VALUE_W-1:0] v);
    logic [31:0] res;
    logic [7:0]  idx;
    v = '0;
    case (op)
      CMD_CLEAR: begin
        foreach (ring_shadow[i]) ring_shadow[i] = 32'h0;
        absorb_slot = '0;
        return 1'b0;
      end
      CMD_ABSORB: begin
        idx = 8'(absorb_slot % DEPTH);
        ring_shadow[idx] = ring_shadow[idx] + {{24{seed[7]}}, seed};
        absorb_slot = 8'((idx + 1) % DEPTH);
        advance_ring();
        return 1'b0;
      end
      CMD_BYTE: begin
        advance_ring();
        res = ring_shadow[0] & BYTE_MASK;
      end
      CMD_HALF: begin
        advance_ring();
        res = ring_shadow[0] & HALF_MASK;
      end
      CMD_WORD: begin
        advance_ring();
        res = ring_shadow[0];
      end
      CMD_DICE: res = roll_shadow(n);
      default:  return 1'b0;
    endcase
    v = res[VALUE_W-1:0];
    return 1'b1;
  endfunction

  task automatic send_beat(logic [CMD_W-1:0] op, logic [SEED_W-1:0] seed,
                           logic [SIDES_W-1:0] n);
    int unsigned gap;
    logic [VALUE_W-1:0] v;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.command   <= op;
    cmd_bus.seed_byte <= seed;
    cmd_bus.sides     <= n;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    if (predict_command(op, seed, n, v)) pending_values.push_back(v);
    beats_sent++;
  endtask

  task automatic test_directed();
    send_beat(CMD_WORD, 8'h00, '0);
    send_beat(CMD_ABSORB, 8'h7F, '0);
    send_beat(CMD_ABSORB, 8'h80, '0);
    send_beat(CMD_ABSORB, 8'hFF, '0);
    send_beat(CMD_ABSORB, 8'h00, '0);
    send_beat(CMD_ABSORB, 8'h55, '0);
    send_beat(CMD_ABSORB, 8'hAA, '0);
    send_beat(CMD_ABSORB, 8'h01, '0);
    send_beat(CMD_ABSORB, 8'hFE, '0);
    send_beat(CMD_ABSORB, 8'h33, '0);
    send_beat(CMD_BYTE, 8'h00, '0);
    send_beat(CMD_HALF, 8'h00, '0);
    send_beat(CMD_WORD, 8'h00, '0);
    send_beat(CMD_DICE, 8'h00, '0);
    send_beat(CMD_DICE, 8'h00, 30'h0000_0001);
    send_beat(CMD_DICE, 8'h00, 30'h2000_0000);
    send_beat(CMD_DICE, 8'h00, 30'h2000_0001);
    send_beat(CMD_DICE, 8'h00, 30'h3FFF_FFFF);
    send_beat(CMD_DICE, 8'h00, 30'h1000_0001);
    send_beat(CMD_DICE, 8'h00, 30'h1555_5555);
    send_beat(CMD_SPARE_LO, 8'hFF, 30'h3FFF_FFFF);
    send_beat(CMD_SPARE_HI, 8'h80, 30'h0000_0006);
    send_beat(CMD_WORD, 8'h00, '0);
    send_beat(CMD_CLEAR, 8'hFF, 30'h3FFF_FFFF);
    send_beat(CMD_WORD, 8'h00, '0);
  endtask

  // host-style seeding: clear, churn the seed text plus suffix, then draw
  task automatic test_seeded_draws(int unsigned upto);
    logic [SEED_W-1:0] seed_text [$];
    int unsigned churn;
    while (beats_sent < upto) begin
      seed_text.delete();
      repeat ($urandom_range(1, 12)) seed_text.push_back(SEED_W'($urandom_range(32, 126)));
      repeat ($urandom_range(0, 6)) seed_text.push_back(SEED_W'($urandom));
      churn = $urandom_range(2, 3 * DEPTH);
      send_beat(CMD_CLEAR, SEED_W'($urandom), SIDES_W'($urandom));
      for (int k = 0; k < churn; k++)
        send_beat(CMD_ABSORB, seed_text[k % seed_text.size()], SIDES_W'($urandom));
      repeat ($urandom_range(2, 10)) send_beat(pick_draw(), SEED_W'($urandom), pick_sides());
    end
  endtask

  task automatic test_back_pressure();
    rx_hold_req = HOLD_CYCLES;
    tx_steady   = 1'b1;
    repeat (16) send_beat(pick_draw(), SEED_W'($urandom), SIDES_W'($urandom_range(1, 50)));
    tx_steady   = 1'b0;
  endtask

  task automatic test_steady_flow();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) send_beat(CMD_ABSORB, SEED_W'($urandom), '0);
      else send_beat(pick_draw(), SEED_W'($urandom), pick_sides());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_noise(int unsigned upto);
    while (beats_sent < upto)
      send_beat(CMD_W'($urandom_range(0, 7)), SEED_W'($urandom), pick_sides());
  endtask

  initial begin : ready_gen
    int unsigned hold_cnt;
    int unsigned rx_stall;
    hold_cnt = 0;
    rx_stall = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_cnt    = rx_hold_req;
        rx_hold_req = 0;
      end
      if (!rst_n) begin
        res_bus.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        res_bus.ready <= 1'b0;
      end else if (rx_steady) begin
        res_bus.ready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        res_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        rx_stall = pick_gap();
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    logic [VALUE_W-1:0] want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (pending_values.size() == 0) begin
        flag_error($sformatf("result beat %0h with nothing pending", res_bus.value));
      end else begin
        want = pending_values.pop_front();
        if (res_bus.value !== want)
          flag_error($sformatf("value exp %0h got %0h", want, res_bus.value));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles < IDLE_LIMIT) begin
      idle_cycles <= idle_cycles + 1;
    end else begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("rotating_fibonacci_ring_rng verification failed");
      $finish;
    end
  end

  initial begin : main
    rst_n             <= 1'b0;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.command   <= CMD_CLEAR;
    cmd_bus.seed_byte <= '0;
    cmd_bus.sides     <= '0;
    foreach (ring_shadow[i]) ring_shadow[i] = 32'h0;
    absorb_slot = '0;
    error_count = 0;
    beats_sent  = 0;
    rx_hold_req = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_seeded_draws(420);
    test_back_pressure();
    test_steady_flow();
    test_noise(650);
    cmd_bus.valid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_values.size() == 0) begin
      $display("rotating_fibonacci_ring_rng verification clean");
    end else begin
      $display("rotating_fibonacci_ring_rng verification failed");
    end
    $finish;
  end

endmodule
